@@ sv/bsrc_pkg.sv @@
// Shared types and constants for the banker's safety request checker.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package bsrc_pkg;

    // Operation carried by one request item.
    typedef enum logic [1:0] {
        OP_LOAD_ALLOC = 2'd0,
        OP_LOAD_MAX   = 2'd1,
        OP_LOAD_AVAIL = 2'd2,
        OP_REQUEST    = 2'd3
    } t_opcode;

    // Outcome of a decision.
    typedef enum logic [2:0] {
        ST_GRANTED       = 3'd0,
        ST_EXCEEDS_NEED  = 3'd1,
        ST_EXCEEDS_AVAIL = 3'd2,
        ST_UNSAFE        = 3'd3,
        ST_BAD_PROCESS   = 3'd4
    } t_status;

    // Configuration register indexes.
    localparam logic REG_ACTIVE_PROCESSES = 1'b0;
    localparam logic REG_ACTIVE_RESOURCES = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  process_index;
        logic [2:0]  resource_index;
        logic [15:0] amount;
        logic        last;
    } t_req_item;

    typedef struct packed {
        logic       granted;
        logic [2:0] status;
        logic [3:0] process_echo;
    } t_result;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHK_RD,
        S_CHK_EV,
        S_CHK_END,
        S_COMMIT,
        S_SAFE_PROC,
        S_SAFE_RD,
        S_SAFE_EV,
        S_SAFE_ADD,
        S_SAFE_END,
        S_ROLL,
        S_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       req_ready;
        logic       clr_step;
        logic       capture_p;
        logic       j_clear;
        logic       j_inc;
        logic       chk_eval;
        logic       commit_step;
        logic       safe_init;
        logic       rd_sel_i;
        logic       safe_eval;
        logic       add_step;
        logic       mark_done;
        logic       i_adv;
        logic       roll_step;
        logic       set_status;
        logic [2:0] status_code;
        logic       out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic start;
        logic bad_p;
        logic j_last;
        logic i_last;
        logic fin_i;
        logic progress;
        logic need_fail;
        logic avail_fail;
        logic fit_fail;
        logic all_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ sv/bsrc_ctrl.sv @@
// Controller state machine of the banker's safety request checker.
// Depends on bsrc_pkg for the state, command and status types.
`default_nettype none

module bsrc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bsrc_pkg::t_sts  i_sts,
    output bsrc_pkg::t_cmd  o_cmd
);

    bsrc_pkg::t_state r_state;
    bsrc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsrc_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bsrc_pkg::S_CLEAR: begin
                if (i_sts.clr_last) n_state = bsrc_pkg::S_IDLE;
            end
            bsrc_pkg::S_IDLE: begin
                if (i_sts.start) begin
                    n_state = i_sts.bad_p ? bsrc_pkg::S_RESULT : bsrc_pkg::S_CHK_RD;
                end
            end
            bsrc_pkg::S_CHK_RD: n_state = bsrc_pkg::S_CHK_EV;
            bsrc_pkg::S_CHK_EV: begin
                n_state = i_sts.j_last ? bsrc_pkg::S_CHK_END : bsrc_pkg::S_CHK_RD;
            end
            bsrc_pkg::S_CHK_END: begin
                if (i_sts.need_fail || i_sts.avail_fail) n_state = bsrc_pkg::S_RESULT;
                else n_state = bsrc_pkg::S_COMMIT;
            end
            bsrc_pkg::S_COMMIT: begin
                if (i_sts.j_last) n_state = bsrc_pkg::S_SAFE_PROC;
            end
            bsrc_pkg::S_SAFE_PROC: begin
                if (!i_sts.fin_i) n_state = bsrc_pkg::S_SAFE_RD;
                else if (i_sts.i_last && !i_sts.progress) n_state = bsrc_pkg::S_SAFE_END;
            end
            bsrc_pkg::S_SAFE_RD: n_state = bsrc_pkg::S_SAFE_EV;
            bsrc_pkg::S_SAFE_EV: begin
                if (i_sts.fit_fail) begin
                    if (i_sts.i_last && !i_sts.progress) n_state = bsrc_pkg::S_SAFE_END;
                    else n_state = bsrc_pkg::S_SAFE_PROC;
                end else if (i_sts.j_last) begin
                    n_state = bsrc_pkg::S_SAFE_ADD;
                end else begin
                    n_state = bsrc_pkg::S_SAFE_RD;
                end
            end
            bsrc_pkg::S_SAFE_ADD: begin
                if (i_sts.j_last) n_state = bsrc_pkg::S_SAFE_PROC;
            end
            bsrc_pkg::S_SAFE_END: begin
                n_state = i_sts.all_done ? bsrc_pkg::S_RESULT : bsrc_pkg::S_ROLL;
            end
            bsrc_pkg::S_ROLL: begin
                if (i_sts.j_last) n_state = bsrc_pkg::S_RESULT;
            end
            bsrc_pkg::S_RESULT: begin
                if (i_sts.out_free) n_state = bsrc_pkg::S_IDLE;
            end
            default: n_state = bsrc_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            bsrc_pkg::S_CLEAR: o_cmd.clr_step = 1'b1;
            bsrc_pkg::S_IDLE: begin
                o_cmd.req_ready = 1'b1;
                if (i_sts.start) begin
                    o_cmd.capture_p = 1'b1;
                    o_cmd.j_clear   = 1'b1;
                    if (i_sts.bad_p) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = bsrc_pkg::ST_BAD_PROCESS;
                    end
                end
            end
            bsrc_pkg::S_CHK_RD: o_cmd.rd_sel_i = 1'b0;
            bsrc_pkg::S_CHK_EV: begin
                o_cmd.chk_eval = 1'b1;
                o_cmd.j_inc    = !i_sts.j_last;
            end
            bsrc_pkg::S_CHK_END: begin
                o_cmd.j_clear = 1'b1;
                if (i_sts.need_fail) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = bsrc_pkg::ST_EXCEEDS_NEED;
                end else if (i_sts.avail_fail) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = bsrc_pkg::ST_EXCEEDS_AVAIL;
                end
            end
            bsrc_pkg::S_COMMIT: begin
                o_cmd.commit_step = 1'b1;
                o_cmd.j_inc       = !i_sts.j_last;
                o_cmd.safe_init   = i_sts.j_last;
            end
            bsrc_pkg::S_SAFE_PROC: begin
                o_cmd.rd_sel_i = 1'b1;
                o_cmd.j_clear  = 1'b1;
                o_cmd.i_adv    = i_sts.fin_i;
            end
            bsrc_pkg::S_SAFE_RD: o_cmd.rd_sel_i = 1'b1;
            bsrc_pkg::S_SAFE_EV: begin
                o_cmd.rd_sel_i = 1'b1;
                if (i_sts.fit_fail) begin
                    o_cmd.i_adv = 1'b1;
                end else begin
                    o_cmd.safe_eval = 1'b1;
                    o_cmd.j_inc     = !i_sts.j_last;
                    o_cmd.j_clear   = i_sts.j_last;
                end
            end
            bsrc_pkg::S_SAFE_ADD: begin
                o_cmd.add_step  = 1'b1;
                o_cmd.j_inc     = !i_sts.j_last;
                o_cmd.mark_done = i_sts.j_last;
                o_cmd.i_adv     = i_sts.j_last;
            end
            bsrc_pkg::S_SAFE_END: begin
                o_cmd.j_clear = 1'b1;
                if (i_sts.all_done) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = bsrc_pkg::ST_GRANTED;
                end
            end
            bsrc_pkg::S_ROLL: begin
                o_cmd.roll_step = 1'b1;
                o_cmd.j_inc     = !i_sts.j_last;
                if (i_sts.j_last) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = bsrc_pkg::ST_UNSAFE;
                end
            end
            bsrc_pkg::S_RESULT: o_cmd.out_load = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/bsrc_dp.sv @@
// Datapath of the banker's safety request checker: matrices, vectors,
// loop counters, compares and the result register. Depends on bsrc_pkg.
`default_nettype none

module bsrc_dp #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8,
    parameter int UNIT_WIDTH    = 16,
    parameter int PCW           = 5,
    parameter int RCW           = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  bsrc_pkg::t_req_item i_req,
    input  logic [PCW-1:0]      i_np,
    input  logic [RCW-1:0]      i_nr,
    input  bsrc_pkg::t_cmd      i_cmd,
    output bsrc_pkg::t_sts      o_sts,
    output logic                o_res_valid,
    input  logic                i_res_stall,
    output bsrc_pkg::t_result   o_res
);

    localparam int PIW   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RIW   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int AW    = PIW + RIW;
    localparam int DEPTH = 2 ** AW;
    localparam int WW    = UNIT_WIDTH + $clog2(MAX_PROCESSES + 1);

    logic [UNIT_WIDTH-1:0] r_mem_alloc [DEPTH];
    logic [UNIT_WIDTH-1:0] r_mem_max   [DEPTH];
    logic [UNIT_WIDTH-1:0] r_alloc_rd;
    logic [UNIT_WIDTH-1:0] r_max_rd;
    logic [UNIT_WIDTH-1:0] r_avail  [MAX_RESOURCES];
    logic [UNIT_WIDTH-1:0] r_reqbuf [MAX_RESOURCES];
    logic [UNIT_WIDTH-1:0] r_row    [MAX_RESOURCES];
    logic [UNIT_WIDTH-1:0] r_addbuf [MAX_RESOURCES];
    logic [WW-1:0]         r_work   [MAX_RESOURCES];
    logic [MAX_PROCESSES-1:0] r_fin;
    logic [PIW-1:0]        r_p;
    logic [PIW-1:0]        r_i;
    logic [RIW-1:0]        r_j;
    logic [AW-1:0]         r_clr;
    logic [PCW-1:0]        r_done;
    logic                  r_progress;
    logic                  r_need_fail;
    logic                  r_avail_fail;
    logic [3:0]            r_echo;
    logic [2:0]            r_status;
    logic                  r_res_valid;
    bsrc_pkg::t_result     r_res;

    logic                  w_accept;
    logic [UNIT_WIDTH-1:0] w_amt;
    logic                  w_p_ok;
    logic                  w_r_ok;
    logic [PIW-1:0]        w_in_p;
    logic [RIW-1:0]        w_in_r;
    logic [AW-1:0]         w_ra;
    logic [AW-1:0]         w_wa;
    logic [UNIT_WIDTH-1:0] w_wd;
    logic                  w_we_alloc;
    logic                  w_we_max;
    logic [UNIT_WIDTH-1:0] w_req_j;
    logic signed [UNIT_WIDTH:0] w_need;
    logic signed [WW:0]    w_need_ext;
    logic                  w_req_gt_need;
    logic                  w_req_gt_avail;
    logic                  w_fit_fail;
    logic                  w_i_last;
    logic                  w_j_last;
    logic                  w_restart;
    logic                  w_out_free;

    assign w_accept = i_req_valid && i_cmd.req_ready;
    assign w_amt    = UNIT_WIDTH'(i_req.amount);
    assign w_p_ok   = 32'(i_req.process_index) < 32'(MAX_PROCESSES);
    assign w_r_ok   = 32'(i_req.resource_index) < 32'(MAX_RESOURCES);
    assign w_in_p   = PIW'(i_req.process_index);
    assign w_in_r   = RIW'(i_req.resource_index);
    assign w_ra     = i_cmd.rd_sel_i ? {r_i, r_j} : {r_p, r_j};

    assign w_req_j        = r_reqbuf[r_j];
    assign w_need         = $signed({1'b0, r_max_rd}) - $signed({1'b0, r_alloc_rd});
    assign w_need_ext     = {{(WW - UNIT_WIDTH){w_need[UNIT_WIDTH]}}, w_need};
    assign w_req_gt_need  = $signed({1'b0, w_req_j}) > w_need;
    assign w_req_gt_avail = w_req_j > r_avail[r_j];
    assign w_fit_fail     = w_need_ext > $signed({1'b0, r_work[r_j]});
    assign w_i_last       = 32'(r_i) == (32'(i_np) - 32'd1);
    assign w_j_last       = 32'(r_j) == (32'(i_nr) - 32'd1);
    assign w_restart      = i_cmd.i_adv && w_i_last && (r_progress || i_cmd.mark_done);
    assign w_out_free     = !r_res_valid || !i_res_stall;

    // Single write port shared by the clearing pass, loads, commit and rollback.
    always_comb begin
        w_we_alloc = 1'b0;
        w_we_max   = 1'b0;
        w_wa       = {r_p, r_j};
        w_wd       = r_row[r_j];
        priority if (i_cmd.clr_step) begin
            w_we_alloc = 1'b1;
            w_we_max   = 1'b1;
            w_wa       = r_clr;
            w_wd       = '0;
        end else if (w_accept && w_p_ok && w_r_ok
                     && i_req.opcode == bsrc_pkg::OP_LOAD_ALLOC) begin
            w_we_alloc = 1'b1;
            w_wa       = {w_in_p, w_in_r};
            w_wd       = w_amt;
        end else if (w_accept && w_p_ok && w_r_ok
                     && i_req.opcode == bsrc_pkg::OP_LOAD_MAX) begin
            w_we_max = 1'b1;
            w_wa     = {w_in_p, w_in_r};
            w_wd     = w_amt;
        end else if (i_cmd.commit_step) begin
            w_we_alloc = 1'b1;
            w_wd       = r_row[r_j] + w_req_j;
        end else if (i_cmd.roll_step) begin
            w_we_alloc = 1'b1;
        end else begin
            w_we_alloc = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we_alloc) r_mem_alloc[w_wa] <= w_wd;
        if (w_we_max) r_mem_max[w_wa] <= w_wd;
        r_alloc_rd <= r_mem_alloc[w_ra];
        r_max_rd   <= r_mem_max[w_ra];
    end

    // State that the model resets to zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_res_valid <= 1'b0;
            for (int k = 0; k < MAX_RESOURCES; k++) begin
                r_avail[k]  <= '0;
                r_reqbuf[k] <= '0;
            end
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + AW'(1);
            if (i_cmd.out_load) r_res_valid <= 1'b1;
            else if (!i_res_stall) r_res_valid <= 1'b0;

            if (w_accept && w_r_ok && i_req.opcode == bsrc_pkg::OP_LOAD_AVAIL) begin
                r_avail[w_in_r] <= w_amt;
            end else if (i_cmd.commit_step) begin
                r_avail[r_j] <= r_avail[r_j] - w_req_j;
            end else if (i_cmd.roll_step) begin
                r_avail[r_j] <= r_avail[r_j] + w_req_j;
            end

            if (i_cmd.out_load) begin
                for (int k = 0; k < MAX_RESOURCES; k++) r_reqbuf[k] <= '0;
            end else if (w_accept && w_r_ok && i_req.opcode == bsrc_pkg::OP_REQUEST) begin
                r_reqbuf[w_in_r] <= w_amt;
            end
        end
    end

    // Loop counters, flags and scratch vectors.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture_p) begin
            r_p          <= w_in_p;
            r_echo       <= i_req.process_index;
            r_need_fail  <= 1'b0;
            r_avail_fail <= 1'b0;
        end
        if (i_cmd.j_clear) r_j <= '0;
        else if (i_cmd.j_inc) r_j <= r_j + RIW'(1);

        if (i_cmd.chk_eval) begin
            r_row[r_j] <= r_alloc_rd;
            if (w_req_gt_need) r_need_fail <= 1'b1;
            if (w_req_gt_avail) r_avail_fail <= 1'b1;
        end
        if (i_cmd.commit_step) r_work[r_j] <= WW'(r_avail[r_j] - w_req_j);
        else if (i_cmd.add_step) r_work[r_j] <= r_work[r_j] + WW'(r_addbuf[r_j]);
        if (i_cmd.safe_eval) r_addbuf[r_j] <= r_alloc_rd;

        if (i_cmd.safe_init) begin
            r_i        <= '0;
            r_fin      <= '0;
            r_done     <= '0;
            r_progress <= 1'b0;
        end else begin
            if (i_cmd.mark_done) begin
                r_fin[r_i] <= 1'b1;
                r_done     <= r_done + PCW'(1);
            end
            if (w_restart) r_progress <= 1'b0;
            else if (i_cmd.mark_done) r_progress <= 1'b1;
            if (w_restart) r_i <= '0;
            else if (i_cmd.i_adv && !w_i_last) r_i <= r_i + PIW'(1);
        end

        if (i_cmd.set_status) r_status <= i_cmd.status_code;
        if (i_cmd.out_load) begin
            r_res.granted      <= r_status == bsrc_pkg::ST_GRANTED;
            r_res.status       <= r_status;
            r_res.process_echo <= r_echo;
        end
    end

    always_comb begin
        o_sts.clr_last   = &r_clr;
        o_sts.start      = w_accept && i_req.opcode == bsrc_pkg::OP_REQUEST && i_req.last;
        o_sts.bad_p      = 32'(i_req.process_index) >= 32'(i_np);
        o_sts.j_last     = w_j_last;
        o_sts.i_last     = w_i_last;
        o_sts.fin_i      = r_fin[r_i];
        o_sts.progress   = r_progress;
        o_sts.need_fail  = r_need_fail;
        o_sts.avail_fail = r_avail_fail;
        o_sts.fit_fail   = w_fit_fail;
        o_sts.all_done   = 32'(r_done) == 32'(i_np);
        o_sts.out_free   = w_out_free;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

@@ sv/bankers_safety_request_checker.sv @@
// Top level of the banker's safety request checker: configuration port,
// count clamping and the controller and datapath. Depends on bsrc_pkg.
//
//   Channel   Direction  Handshake                      Payload
//   request   in         i_req_valid / o_req_stall      i_req (t_req_item)
//   result    out        o_res_valid / i_res_stall      o_res (t_result)
//   config    in         psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// Load requests are written as they are taken. A deciding request (request
// element with last set) checks each element against need and available,
// commits it, then runs up to np + 1 passes of the safety loop, reading,
// comparing and adding one element at a time; the single read port of the
// allocation and maximum memories sets this pace. A rollback undoes an
// unsafe commit element by element. After reset a clearing pass over all
// 2**(log2(processes)+log2(resources)) addresses (128 by default) zeroes
// both memories; no request is taken then. A finished result waits in the
// output register while new loads enter.
`default_nettype none

module bankers_safety_request_checker #(
    parameter int MAX_PROCESSES = 16,
    parameter int MAX_RESOURCES = 8,
    parameter int UNIT_WIDTH    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_stall,
    input  bsrc_pkg::t_req_item i_req,
    output logic                o_res_valid,
    input  logic                i_res_stall,
    output bsrc_pkg::t_result   o_res,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int PCW = $clog2(MAX_PROCESSES + 1);
    localparam int RCW = $clog2(MAX_RESOURCES + 1);

    logic [4:0]     r_active_processes;
    logic [3:0]     r_active_resources;
    logic [PCW-1:0] w_np;
    logic [RCW-1:0] w_nr;
    logic           w_cfg_write;
    bsrc_pkg::t_cmd w_cmd;
    bsrc_pkg::t_sts w_sts;

    // The register index sits in address bit 2; the low bits are ignored.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_processes <= 5'd16;
            r_active_resources <= 4'd8;
        end else if (w_cfg_write) begin
            if (paddr[2] == bsrc_pkg::REG_ACTIVE_PROCESSES) begin
                r_active_processes <= pwdata[4:0];
            end else begin
                r_active_resources <= pwdata[3:0];
            end
        end
    end

    assign prdata = (paddr[2] == bsrc_pkg::REG_ACTIVE_PROCESSES)
                    ? 32'(r_active_processes) : 32'(r_active_resources);

    // A count of zero acts as one, and a count above the storage acts as
    // the storage size.
    always_comb begin
        priority if (r_active_processes == '0) w_np = PCW'(1);
        else if (32'(r_active_processes) > 32'(MAX_PROCESSES)) w_np = PCW'(MAX_PROCESSES);
        else w_np = PCW'(r_active_processes);
        priority if (r_active_resources == '0) w_nr = RCW'(1);
        else if (32'(r_active_resources) > 32'(MAX_RESOURCES)) w_nr = RCW'(MAX_RESOURCES);
        else w_nr = RCW'(r_active_resources);
    end

    // Requests are taken only while the controller is idle.
    assign o_req_stall = !w_cmd.req_ready;

    bsrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    bsrc_dp #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES),
        .UNIT_WIDTH    (UNIT_WIDTH),
        .PCW           (PCW),
        .RCW           (RCW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .i_np        (w_np),
        .i_nr        (w_nr),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_res       (o_res)
    );

`ifndef SYNTHESIS
    // Granted is set exactly when the status says granted.
    a_granted_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.granted == (o_res.status == bsrc_pkg::ST_GRANTED)))
        else $error("granted flag disagrees with status");

    // A deciding request stops intake on the next cycle.
    a_decide_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall && i_req.opcode == bsrc_pkg::OP_REQUEST
         && i_req.last) |=> o_req_stall)
        else $error("intake not stopped during a decision");

    // A bad process status is only given for an index outside the active set.
    a_bad_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == bsrc_pkg::ST_BAD_PROCESS)
        |-> (32'(o_res.process_echo) >= 32'(w_np)))
        else $error("bad process status for an active process");
`endif

endmodule

`default_nettype wire

@@ dv/bankers_safety_request_checker_test.sv @@
// Self-checking testbench for the banker's safety request checker.
// Depends on bsrc_pkg and the bankers_safety_request_checker top level.
`default_nettype none

module bankers_safety_request_checker_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROC = 16;
    localparam int NRES  = 8;

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    bsrc_pkg::t_req_item req;
    logic                res_valid;
    logic                res_stall;
    bsrc_pkg::t_result   res;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    bankers_safety_request_checker u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_stall (req_stall),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_stall (res_stall),
        .o_res       (res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // The clock runs with a 10 ns period.
    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Shadow copy of the block's state, used to predict each decision.
    logic [15:0] alloc_shadow [NPROC][NRES];
    logic [15:0] max_shadow   [NPROC][NRES];
    logic [15:0] avail_shadow [NRES];
    logic [15:0] pending_elems [NRES];
    logic [4:0]  procs_reg;
    logic [3:0]  res_reg;

    bsrc_pkg::t_result expected_decisions [$];
    int          mismatches;
    int          decisions_seen;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off_cycles;

    function automatic int clamp_count(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Safety pass over the shadow state: true if every active process can finish.
    function automatic bit state_is_safe(int np, int nr);
        longint work [NRES];
        bit     done [NPROC];
        bit     progress;
        bit     fits;
        for (int j = 0; j < NRES; j++) work[j] = (j < nr) ? avail_shadow[j] : 0;
        for (int i = 0; i < NPROC; i++) done[i] = 1'b0;
        progress = 1'b1;
        while (progress) begin
            progress = 1'b0;
            for (int i = 0; i < np; i++) begin
                if (!done[i]) begin
                    fits = 1'b1;
                    for (int j = 0; j < nr; j++) begin
                        if (longint'(max_shadow[i][j]) - longint'(alloc_shadow[i][j])
                            > work[j]) fits = 1'b0;
                    end
                    if (fits) begin
                        for (int j = 0; j < nr; j++) work[j] += alloc_shadow[i][j];
                        done[i]  = 1'b1;
                        progress = 1'b1;
                    end
                end
            end
        end
        for (int i = 0; i < np; i++) if (!done[i]) return 1'b0;
        return 1'b1;
    endfunction

    // Decide a request against the shadow state and commit it if granted.
    function automatic bsrc_pkg::t_status decide_request(int p);
        int np;
        int nr;
        np = clamp_count(procs_reg, NPROC);
        nr = clamp_count(res_reg, NRES);
        if (p >= np) return bsrc_pkg::ST_BAD_PROCESS;
        for (int j = 0; j < nr; j++)
            if (longint'(pending_elems[j]) >
                longint'(max_shadow[p][j]) - longint'(alloc_shadow[p][j]))
                return bsrc_pkg::ST_EXCEEDS_NEED;
        for (int j = 0; j < nr; j++)
            if (pending_elems[j] > avail_shadow[j]) return bsrc_pkg::ST_EXCEEDS_AVAIL;
        for (int j = 0; j < nr; j++) begin
            avail_shadow[j]    -= pending_elems[j];
            alloc_shadow[p][j] += pending_elems[j];
        end
        if (!state_is_safe(np, nr)) begin
            for (int j = 0; j < nr; j++) begin
                avail_shadow[j]    += pending_elems[j];
                alloc_shadow[p][j] -= pending_elems[j];
            end
            return bsrc_pkg::ST_UNSAFE;
        end
        return bsrc_pkg::ST_GRANTED;
    endfunction

    // Apply one accepted request to the shadow state; queue a result if it decides.
    function automatic void predict_request(bsrc_pkg::t_req_item it);
        bsrc_pkg::t_status st;
        bsrc_pkg::t_result r;
        case (bsrc_pkg::t_opcode'(it.opcode))
            bsrc_pkg::OP_LOAD_ALLOC:
                alloc_shadow[it.process_index][it.resource_index] = it.amount;
            bsrc_pkg::OP_LOAD_MAX:
                max_shadow[it.process_index][it.resource_index] = it.amount;
            bsrc_pkg::OP_LOAD_AVAIL: avail_shadow[it.resource_index] = it.amount;
            default: begin
                pending_elems[it.resource_index] = it.amount;
                if (it.last) begin
                    st = decide_request(it.process_index);
                    for (int j = 0; j < NRES; j++) pending_elems[j] = '0;
                    r.granted      = (st == bsrc_pkg::ST_GRANTED);
                    r.status       = st;
                    r.process_echo = it.process_index;
                    expected_decisions.push_back(r);
                end
            end
        endcase
    endfunction

    // Offer one request, idling first at random, and wait until it is taken.
    // Valid stays high after the request is taken until the next request or an idle.
    task automatic send_request(bsrc_pkg::t_req_item it);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        predict_request(it);
        @(negedge clk);
    endtask

    task automatic send_fields(bsrc_pkg::t_opcode op, int p, int r, int amt, bit lst);
        bsrc_pkg::t_req_item it;
        it.opcode         = op;
        it.process_index  = 4'(p);
        it.resource_index = 3'(r);
        it.amount         = 16'(amt);
        it.last           = lst;
        send_request(it);
    endtask

    // Write one register through the APB port; the block must be idle.
    task automatic write_register(logic idx, int value);
        procs_reg = (idx == bsrc_pkg::REG_ACTIVE_PROCESSES) ? value[4:0] : procs_reg;
        res_reg   = (idx == bsrc_pkg::REG_ACTIVE_RESOURCES) ? value[3:0] : res_reg;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait for all outstanding decisions, then for the block to go quiet.
    task automatic drain();
        int guard;
        guard = 0;
        req_valid <= 1'b0;
        while (expected_decisions.size() != 0 && guard < 2000000) begin
            @(posedge clk);
            guard++;
        end
        repeat (6500) @(posedge clk);
        @(negedge clk);
    endtask

    // A mostly well-formed request: process usually active, elements usually within need.
    task automatic send_random_request(int np, int nr);
        int p;
        int cnt;
        int need;
        p   = ($urandom_range(9, 0) == 0) ? $urandom_range(15, 0) : $urandom_range(np - 1, 0);
        cnt = $urandom_range(nr, 1);
        for (int k = 0; k < cnt; k++) begin
            int r;
            int amt;
            r    = $urandom_range(NRES - 1, 0);
            need = int'(max_shadow[p][r]) - int'(alloc_shadow[p][r]);
            if ($urandom_range(7, 0) == 0 || need <= 0)
                amt = $urandom_range(65535, 0);
            else
                amt = $urandom_range(need, 0);
            send_fields(bsrc_pkg::OP_REQUEST, p, r, amt, k == cnt - 1);
        end
    endtask

    // Load a random but mostly consistent system of claims and holdings.
    task automatic load_random_system(int np, int nr);
        for (int i = 0; i < np; i++) begin
            for (int j = 0; j < nr; j++) begin
                int mx;
                mx = $urandom_range(12, 0);
                send_fields(bsrc_pkg::OP_LOAD_MAX, i, j, mx, 1'($urandom_range(1, 0)));
                send_fields(bsrc_pkg::OP_LOAD_ALLOC, i, j,
                            ($urandom_range(15, 0) == 0) ? mx + 1 : $urandom_range(mx, 0),
                            1'($urandom_range(1, 0)));
            end
        end
        for (int j = 0; j < nr; j++)
            send_fields(bsrc_pkg::OP_LOAD_AVAIL, 0, j, $urandom_range(10, 0), 1'b0);
    endtask

    // Directed checks: extreme amounts, every opcode and every outcome.
    task automatic test_directed();
        send_fields(bsrc_pkg::OP_REQUEST, 0, 0, 0, 1'b1);          // empty request on zero state
        send_fields(bsrc_pkg::OP_LOAD_MAX, 15, 7, 16'hFFFF, 1'b1); // last on a load does nothing
        send_fields(bsrc_pkg::OP_LOAD_AVAIL, 0, 7, 16'hFFFF, 1'b0);
        send_fields(bsrc_pkg::OP_REQUEST, 15, 7, 16'hFFFF, 1'b1);  // full grant at the extremes
        send_fields(bsrc_pkg::OP_REQUEST, 15, 7, 1, 1'b1);         // now exceeds need
        send_fields(bsrc_pkg::OP_LOAD_MAX, 3, 2, 5, 1'b0);
        send_fields(bsrc_pkg::OP_REQUEST, 3, 2, 4, 1'b1);          // exceeds available
        send_fields(bsrc_pkg::OP_LOAD_AVAIL, 2, 2, 4, 1'b0);
        send_fields(bsrc_pkg::OP_LOAD_MAX, 4, 2, 9, 1'b0);
        send_fields(bsrc_pkg::OP_LOAD_ALLOC, 4, 2, 1, 1'b0);
        send_fields(bsrc_pkg::OP_REQUEST, 3, 2, 4, 1'b1);          // leaves process 4 stuck
        send_fields(bsrc_pkg::OP_LOAD_ALLOC, 5, 1, 3, 1'b0);       // allocation above maximum
        send_fields(bsrc_pkg::OP_REQUEST, 5, 1, 0, 1'b0);
        send_fields(bsrc_pkg::OP_REQUEST, 5, 0, 0, 1'b1);          // negative need, zero request
        send_fields(bsrc_pkg::OP_REQUEST, 5, 1, 1, 1'b1);          // negative need exceeded
        send_fields(bsrc_pkg::OP_REQUEST, 3, 2, 1, 1'b1);
        drain();
        write_register(bsrc_pkg::REG_ACTIVE_PROCESSES, 4);
        write_register(bsrc_pkg::REG_ACTIVE_RESOURCES, 1);
        send_fields(bsrc_pkg::OP_REQUEST, 4, 0, 0, 1'b1);          // bad process index
        send_fields(bsrc_pkg::OP_REQUEST, 3, 5, 16'hFFFF, 1'b0);   // beyond active resources
        send_fields(bsrc_pkg::OP_REQUEST, 3, 0, 0, 1'b1);
        drain();
        write_register(bsrc_pkg::REG_ACTIVE_PROCESSES, 0);         // zero acts as one
        write_register(bsrc_pkg::REG_ACTIVE_RESOURCES, 15);        // above the limit acts as eight
        send_fields(bsrc_pkg::OP_REQUEST, 1, 0, 0, 1'b1);
        send_fields(bsrc_pkg::OP_REQUEST, 0, 0, 0, 1'b1);
        drain();
        write_register(bsrc_pkg::REG_ACTIVE_PROCESSES, 31);
        write_register(bsrc_pkg::REG_ACTIVE_RESOURCES, 0);
        send_fields(bsrc_pkg::OP_REQUEST, 15, 0, 0, 1'b1);
        drain();
    endtask

    // Random phase under one register setting and one idling pattern.
    task automatic test_random_phase(int np_cfg, int nr_cfg, int sidle, int ridle, int n);
        int np;
        int nr;
        write_register(bsrc_pkg::REG_ACTIVE_PROCESSES, np_cfg);
        write_register(bsrc_pkg::REG_ACTIVE_RESOURCES, nr_cfg);
        np = clamp_count(np_cfg, NPROC);
        nr = clamp_count(nr_cfg, NRES);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        load_random_system(np, nr);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(9, 0) == 0)
                send_fields(bsrc_pkg::t_opcode'($urandom_range(3, 0)), $urandom_range(15, 0),
                            $urandom_range(7, 0), $urandom_range(65535, 0),
                            1'($urandom_range(1, 0)));
            else if ($urandom_range(5, 0) == 0)
                send_fields(bsrc_pkg::OP_LOAD_AVAIL, 0, $urandom_range(nr - 1, 0),
                            $urandom_range(12, 0), 1'b0);
            else
                send_random_request(np, nr);
        end
        drain();
    endtask

    // The receiver stalls for a long stretch while decisions keep coming.
    task automatic test_result_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 3000;
        for (int k = 0; k < 6; k++) send_fields(bsrc_pkg::OP_REQUEST, k, 0, 0, 1'b1);
        drain();
    endtask

    // Result stall: random idling, or a counted hold-off when one is requested.
    always @(negedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            res_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            res_stall <= ($urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest expected decision.
    always @(posedge clk) begin
        if (rst_n && res_valid && !res_stall) begin
            decisions_seen++;
            if (expected_decisions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: granted=%0d status=%0d process=%0d",
                             res.granted, res.status, res.process_echo);
            end else begin
                bsrc_pkg::t_result exp_r;
                exp_r = expected_decisions.pop_front();
                if (res.granted !== exp_r.granted || res.status !== exp_r.status ||
                    res.process_echo !== exp_r.process_echo) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 exp_r.granted, exp_r.status, exp_r.process_echo,
                                 res.granted, res.status, res.process_echo);
                end
            end
        end
    end

    initial begin
        #200_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        mismatches      = 0;
        decisions_seen  = 0;
        send_idle_pct   = 13;
        recv_idle_pct   = 68;
        hold_off_cycles = 0;
        procs_reg = 5'd16;
        res_reg   = 4'd8;
        for (int i = 0; i < NPROC; i++)
            for (int j = 0; j < NRES; j++) begin
                alloc_shadow[i][j] = '0;
                max_shadow[i][j]   = '0;
            end
        for (int j = 0; j < NRES; j++) begin
            avail_shadow[j]  = '0;
            pending_elems[j] = '0;
        end
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_phase(8, 4, 13, 68, 12);
        test_random_phase(3, 2, 68, 13, 25);
        test_random_phase(1, 1, 68, 13, 10);
        test_random_phase(16, 2, 0, 0, 20);
        test_result_backpressure();

        if (expected_decisions.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

`default_nettype wire
